### sv/perimeter_wire_follow_steering_top_macros.svh
// Assertion macros for the perimeter wire follow steering block.
// The checks are compiled for simulation only.
`ifndef PERIMETER_WIRE_FOLLOW_STEERING_TOP_MACROS_SVH
`define PERIMETER_WIRE_FOLLOW_STEERING_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on the rising edge outside reset.
`define PWFS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwfs: same-cycle check failed");

// Next-cycle implication, checked on the rising edge outside reset.
`define PWFS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwfs: next-cycle check failed");

`else

`define PWFS_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define PWFS_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

### sv/pwfs_pkg.sv
package pwfs_pkg;

    // Width of the shared add/subtract unit: a 15-bit magnitude times an 8-bit speed.
    localparam int ALU_W = 23;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SLOW_LEFT     = 3'd0;
    localparam logic [2:0] CFG_SLOW_RIGHT    = 3'd1;
    localparam logic [2:0] CFG_MAX_MAG_IN    = 3'd2;
    localparam logic [2:0] CFG_MAX_MAG_OUT   = 3'd3;
    localparam logic [2:0] CFG_MAX_SAME_SIDE = 3'd4;
    localparam logic [2:0] CFG_CLOCKWISE     = 3'd5;
    localparam logic [2:0] CFG_ZONE1_TIME    = 3'd6;
    localparam logic [2:0] CFG_ZONE2_TIME    = 3'd7;

    // Register values after reset.
    localparam logic [7:0]  RST_SLOW_SPEED    = 8'd100;
    localparam logic [14:0] RST_MAX_MAG       = 15'd1000;
    localparam logic [15:0] RST_MAX_SAME_SIDE = 16'd2000;
    localparam logic        RST_CLOCKWISE     = 1'b1;
    localparam logic [31:0] RST_ZONE1_TIME    = 32'd60000;
    localparam logic [31:0] RST_ZONE2_TIME    = 32'd120000;

    // Request kinds.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Zone codes.
    localparam logic [1:0] ZONE_ONE = 2'd1;
    localparam logic [1:0] ZONE_TWO = 2'd2;

    // Drive modes.
    localparam logic [1:0] MODE_FORWARD   = 2'd0;
    localparam logic [1:0] MODE_ROT_LEFT  = 2'd1;
    localparam logic [1:0] MODE_ROT_RIGHT = 2'd2;
    localparam logic [1:0] MODE_STOPPED   = 2'd3;

    // Exit codes.
    localparam logic [1:0] EXIT_STAY   = 2'd0;
    localparam logic [1:0] EXIT_PARKED = 2'd1;
    localparam logic [1:0] EXIT_DOCKED = 2'd2;
    localparam logic [1:0] EXIT_GARDEN = 2'd3;

    typedef struct packed {
        logic [7:0]  slow_speed_left;
        logic [7:0]  slow_speed_right;
        logic [14:0] max_mag_inside;
        logic [14:0] max_mag_outside;
        logic [15:0] max_same_side_ms;
        logic        clockwise;
        logic [31:0] zone1_time_ms;
        logic [31:0] zone2_time_ms;
    } t_cfg;

    typedef struct packed {
        logic              command;
        logic signed [15:0] magnitude;
        logic              inside_req;
        logic [15:0]       elapsed_ms;
        logic              stop_key;
        logic              charging;
        logic [1:0]        zone;
    } t_item;

    typedef struct packed {
        logic [1:0] exit_to;
        logic [1:0] drive_mode;
        logic [7:0] right_speed;
        logic [7:0] left_speed;
    } t_result;

endpackage

### sv/pwfs_alu.sv
module pwfs_alu (
    input  logic [pwfs_pkg::ALU_W-1:0] i_a,
    input  logic [pwfs_pkg::ALU_W-1:0] i_b,
    input  logic                       i_sub,
    output logic [pwfs_pkg::ALU_W:0]   o_sum
);

    // Add, or subtract by adding the inverted operand plus one.
    // In subtract mode the top bit is set when i_b exceeds i_a.
    assign o_sum = {1'b0, i_a}
                 + ({1'b0, i_b} ^ {(pwfs_pkg::ALU_W + 1){i_sub}})
                 + {{pwfs_pkg::ALU_W{1'b0}}, i_sub};

endmodule

### sv/pwfs_core.sv
module pwfs_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pwfs_pkg::t_item   i_item,
    input  pwfs_pkg::t_cfg    i_cfg,
    output logic              o_idle,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output pwfs_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_APPLY,
        S_FIN,
        S_DONE
    } t_state;

    t_state            r_state;
    pwfs_pkg::t_item   r_item;
    pwfs_pkg::t_result r_res;
    logic              r_last_side;
    logic [31:0]       r_same_time;
    logic [31:0]       r_since_start;
    logic [7:0]        r_held_left;
    logic [7:0]        r_held_right;
    logic [1:0]        r_held_mode;
    logic              r_zone_exp;
    logic [14:0]       r_opnd;
    logic [pwfs_pkg::ALU_W-1:0] r_acc;
    logic [pwfs_pkg::ALU_W-1:0] r_div;
    logic [7:0]        r_q;
    logic [2:0]        r_cnt;

    logic        negative;
    logic [15:0] mag_u;
    logic [15:0] abs_mag;
    logic [14:0] limit;
    logic [14:0] clamped;
    logic        brake_left;
    logic [7:0]  slow_sel;
    logic [32:0] since_sum;
    logic [31:0] since_new;
    logic [32:0] same_sum;
    logic [31:0] side_new;
    logic        rotate;
    logic        zone_exp;
    logic [1:0]  rot_mode;

    logic [pwfs_pkg::ALU_W-1:0] alu_a;
    logic [pwfs_pkg::ALU_W-1:0] alu_b;
    logic                       alu_sub;
    logic [pwfs_pkg::ALU_W:0]   alu_sum;

    // Decode of the held tick: sign, clamp, timers and the decisions that follow.
    always_comb begin
        negative   = r_item.magnitude[15];
        mag_u      = $unsigned(r_item.magnitude);
        abs_mag    = negative ? (16'd0 - mag_u) : mag_u;
        limit      = negative ? i_cfg.max_mag_inside : i_cfg.max_mag_outside;
        clamped    = (abs_mag > {1'b0, limit}) ? limit : abs_mag[14:0];
        brake_left = i_cfg.clockwise ^ negative;
        slow_sel   = brake_left ? i_cfg.slow_speed_left : i_cfg.slow_speed_right;
        rot_mode   = brake_left ? pwfs_pkg::MODE_ROT_LEFT : pwfs_pkg::MODE_ROT_RIGHT;

        since_sum = {1'b0, r_since_start} + {17'd0, r_item.elapsed_ms};
        since_new = since_sum[32] ? 32'hFFFF_FFFF : since_sum[31:0];
        same_sum  = {1'b0, r_same_time} + {17'd0, r_item.elapsed_ms};
        if (r_last_side != r_item.inside_req) begin
            side_new = 32'd0;
        end else begin
            side_new = same_sum[32] ? 32'hFFFF_FFFF : same_sum[31:0];
        end
        rotate   = side_new > {16'd0, i_cfg.max_same_side_ms};
        zone_exp = ((r_item.zone == pwfs_pkg::ZONE_ONE) && (since_new >= i_cfg.zone1_time_ms))
                || ((r_item.zone == pwfs_pkg::ZONE_TWO) && (since_new >= i_cfg.zone2_time_ms));
    end

    // Operand selection for the shared unit: shift-add, trial subtract, final subtract.
    always_comb begin
        unique case (r_state)
            S_MUL: begin
                alu_a   = {r_acc[pwfs_pkg::ALU_W-2:0], 1'b0};
                alu_b   = slow_sel[r_cnt] ? {8'd0, r_opnd} : '0;
                alu_sub = 1'b0;
            end
            S_DIV: begin
                alu_a   = r_acc;
                alu_b   = r_div;
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = {15'd0, slow_sel};
                alu_b   = {15'd0, r_q};
                alu_sub = 1'b1;
            end
        endcase
    end

    pwfs_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    // Sequencer: evaluate the request, then multiply and divide for the braking term.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_last_side   <= 1'b0;
            r_same_time   <= 32'd0;
            r_since_start <= 32'd0;
            r_held_left   <= 8'd0;
            r_held_right  <= 8'd0;
            r_held_mode   <= pwfs_pkg::MODE_FORWARD;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_item  <= i_item;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_item.command == pwfs_pkg::CMD_START) begin
                        r_same_time   <= 32'd0;
                        r_since_start <= 32'd0;
                        r_held_left   <= 8'd0;
                        r_held_right  <= 8'd0;
                        r_held_mode   <= pwfs_pkg::MODE_FORWARD;
                        r_last_side   <= r_item.inside_req;
                        r_res   <= '{pwfs_pkg::EXIT_STAY, pwfs_pkg::MODE_FORWARD, 8'd0, 8'd0};
                        r_state <= S_DONE;
                    end else if (r_item.stop_key) begin
                        r_res   <= '{pwfs_pkg::EXIT_PARKED, pwfs_pkg::MODE_STOPPED, 8'd0, 8'd0};
                        r_state <= S_DONE;
                    end else if (r_item.charging) begin
                        r_res   <= '{pwfs_pkg::EXIT_DOCKED, pwfs_pkg::MODE_STOPPED, 8'd0, 8'd0};
                        r_state <= S_DONE;
                    end else begin
                        r_since_start <= since_new;
                        r_zone_exp    <= zone_exp;
                        r_state       <= S_FIN;
                        if (mag_u != 16'd0) begin
                            r_same_time <= side_new;
                            r_last_side <= r_item.inside_req;
                            if (rotate) begin
                                r_held_left  <= i_cfg.slow_speed_left;
                                r_held_right <= i_cfg.slow_speed_right;
                                r_held_mode  <= rot_mode;
                            end else if (limit == 15'd0) begin
                                // A zero limit brakes the wheel fully.
                                r_held_left  <= brake_left ? 8'd0 : i_cfg.slow_speed_left;
                                r_held_right <= brake_left ? i_cfg.slow_speed_right : 8'd0;
                                r_held_mode  <= pwfs_pkg::MODE_FORWARD;
                            end else begin
                                r_opnd  <= clamped;
                                r_acc   <= '0;
                                r_cnt   <= 3'd7;
                                r_state <= S_MUL;
                            end
                        end
                    end
                end
                S_MUL: begin
                    // One bit of the speed per cycle, most significant first.
                    r_acc <= alu_sum[pwfs_pkg::ALU_W-1:0];
                    if (r_cnt == 3'd0) begin
                        r_div   <= {1'b0, limit, 7'd0};
                        r_cnt   <= 3'd7;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt - 3'd1;
                    end
                end
                S_DIV: begin
                    // Restoring division: the quotient never exceeds the speed.
                    if (!alu_sum[pwfs_pkg::ALU_W]) begin
                        r_acc <= alu_sum[pwfs_pkg::ALU_W-1:0];
                    end
                    r_q[r_cnt] <= !alu_sum[pwfs_pkg::ALU_W];
                    r_div      <= r_div >> 1;
                    if (r_cnt == 3'd0) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_cnt <= r_cnt - 3'd1;
                    end
                end
                S_APPLY: begin
                    r_held_left  <= brake_left ? alu_sum[7:0] : i_cfg.slow_speed_left;
                    r_held_right <= brake_left ? i_cfg.slow_speed_right : alu_sum[7:0];
                    r_held_mode  <= pwfs_pkg::MODE_FORWARD;
                    r_state      <= S_FIN;
                end
                S_FIN: begin
                    if (r_zone_exp) begin
                        r_res <= '{pwfs_pkg::EXIT_GARDEN, pwfs_pkg::MODE_STOPPED, 8'd0, 8'd0};
                    end else begin
                        r_res <= '{pwfs_pkg::EXIT_STAY, r_held_mode, r_held_right, r_held_left};
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

### sv/perimeter_wire_follow_steering_top.sv
// Perimeter wire follow steering. Each request on the slave stream is a start command or a
// control tick and yields exactly one result on the master stream. The block takes one request
// at a time. Start, stop and charging requests and ticks that need no braking term (zero
// magnitude, rotation or a zero limit) skip the arithmetic; a braking tick runs the 8-step
// shift-add multiply and 8-step restoring divide that share one 23-bit adder. A finished
// result waits in an output register, so the next request is taken while it is still held.
// Configuration writes are always accepted and take effect at once.
`include "perimeter_wire_follow_steering_top_macros.svh"

module perimeter_wire_follow_steering_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: magnitude[15:0], inside_req[16], elapsed_ms[32:17], stop_key[33],
    // charging[34], zone[36:35], zero fill[39:37]
    input  logic [39:0] s_axis_tdata,
    // tuser: command[0]
    input  logic        s_axis_tuser,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: left_speed[7:0], right_speed[15:8], drive_mode[17:16],
    // exit_to[19:18], zero fill[23:20]
    output logic [23:0] m_axis_tdata,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    pwfs_pkg::t_cfg    r_cfg;
    pwfs_pkg::t_item   in_item;
    pwfs_pkg::t_result core_res;
    pwfs_pkg::t_result r_out;
    logic              r_out_valid;
    logic              core_idle;
    logic              core_res_valid;
    logic              core_res_ready;
    logic              in_accept;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow_speed_left  <= pwfs_pkg::RST_SLOW_SPEED;
            r_cfg.slow_speed_right <= pwfs_pkg::RST_SLOW_SPEED;
            r_cfg.max_mag_inside   <= pwfs_pkg::RST_MAX_MAG;
            r_cfg.max_mag_outside  <= pwfs_pkg::RST_MAX_MAG;
            r_cfg.max_same_side_ms <= pwfs_pkg::RST_MAX_SAME_SIDE;
            r_cfg.clockwise        <= pwfs_pkg::RST_CLOCKWISE;
            r_cfg.zone1_time_ms    <= pwfs_pkg::RST_ZONE1_TIME;
            r_cfg.zone2_time_ms    <= pwfs_pkg::RST_ZONE2_TIME;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pwfs_pkg::CFG_SLOW_LEFT:     r_cfg.slow_speed_left  <= i_cfg_data[7:0];
                pwfs_pkg::CFG_SLOW_RIGHT:    r_cfg.slow_speed_right <= i_cfg_data[7:0];
                pwfs_pkg::CFG_MAX_MAG_IN:    r_cfg.max_mag_inside   <= i_cfg_data[14:0];
                pwfs_pkg::CFG_MAX_MAG_OUT:   r_cfg.max_mag_outside  <= i_cfg_data[14:0];
                pwfs_pkg::CFG_MAX_SAME_SIDE: r_cfg.max_same_side_ms <= i_cfg_data[15:0];
                pwfs_pkg::CFG_CLOCKWISE:     r_cfg.clockwise        <= i_cfg_data[0];
                pwfs_pkg::CFG_ZONE1_TIME:    r_cfg.zone1_time_ms    <= i_cfg_data;
                pwfs_pkg::CFG_ZONE2_TIME:    r_cfg.zone2_time_ms    <= i_cfg_data;
            endcase
        end
    end

    // Unpack the request.
    always_comb begin
        in_item.command    = s_axis_tuser;
        in_item.magnitude  = $signed(s_axis_tdata[15:0]);
        in_item.inside_req = s_axis_tdata[16];
        in_item.elapsed_ms = s_axis_tdata[32:17];
        in_item.stop_key   = s_axis_tdata[33];
        in_item.charging   = s_axis_tdata[34];
        in_item.zone       = s_axis_tdata[36:35];
    end

    assign s_axis_tready = core_idle;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    pwfs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_accept),
        .i_item      (in_item),
        .i_cfg       (r_cfg),
        .o_idle      (core_idle),
        .o_res_valid (core_res_valid),
        .i_res_ready (core_res_ready),
        .o_res       (core_res)
    );

    // Output register: loads when empty or when its result is being taken.
    assign core_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res_ready) begin
            r_out_valid <= core_res_valid;
            if (core_res_valid) begin
                r_out <= core_res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.exit_to, r_out.drive_mode,
                            r_out.right_speed, r_out.left_speed};

    // A request keeps the block busy for at least the following cycle.
    `PWFS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, !s_axis_tready)

    // A result handed over by the core is shown on the next cycle.
    `PWFS_ASSERT_NEXT(a_handoff_shown, i_clk, i_rst_n,
                      core_res_valid && core_res_ready, m_axis_tvalid)

    // The stopped mode goes with every exit, and only with an exit.
    `PWFS_ASSERT_IMPL(a_stop_matches_exit, i_clk, i_rst_n, m_axis_tvalid,
                      (r_out.drive_mode == pwfs_pkg::MODE_STOPPED)
                      == (r_out.exit_to != pwfs_pkg::EXIT_STAY))

endmodule
